// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dte_pkg.sv
// Shared constants, types and tables for the datetime to epoch seconds core.
package dte_pkg;

	localparam int YEAR_W   = 15;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int OFFS_W   = 12;
	localparam int TZ_W     = 11;
	localparam int EPOCH_W  = 40;
	localparam int IN_DATA_W = 56;
	localparam int NSTG     = 6;

	localparam logic [TZ_W-1:0] TZ_LIMIT_RESET = 11'd840;

	// Year biases that make the era and mod-25 arithmetic non-negative.
	localparam logic [16:0] ERA_YEAR_BIAS = 17'd16800;
	localparam logic [7:0]  ERA_BIAS      = 8'd42;
	localparam logic [16:0] Y25_BIAS      = 17'd16400;
	localparam logic [22:0] RECIP_25_A    = 23'd1311;
	localparam logic [28:0] RECIP_25_B    = 29'd5243;
	localparam logic [15:0] YEARS_ERA     = 16'd400;

	localparam logic signed [23:0] DAYS_ERA    = 24'sd146097;
	localparam logic signed [23:0] EPOCH_SHIFT = 24'sd719468;
	localparam logic signed [41:0] SECS_DAY    = 42'sd86400;
	localparam logic signed [41:0] EPOCH_MAX   = (42'sd1 <<< (EPOCH_W - 1)) - 42'sd1;
	localparam logic signed [41:0] EPOCH_MIN   = -(42'sd1 <<< (EPOCH_W - 1));

	typedef struct packed {
		logic                ok;
		logic signed [7:0]   era;
		logic [17:0]         doe;
		logic signed [18:0]  tsec;
	} cal_t;

	// Day of the March-based year on which each month starts.
	function automatic logic [8:0] doy_base(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                              r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:           r = 5'd30;
			default:                           r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/dte_calendar.sv
// Front stages: field checks, era split, leap test and day-of-era count.
module dte_calendar import dte_pkg::*; (
	input  logic                     clk,
	input  logic [2:0]               en,
	input  logic [YEAR_W-1:0]        year,
	input  logic [MONTH_W-1:0]       month,
	input  logic [DAY_W-1:0]         day,
	input  logic [HOUR_W-1:0]        hour,
	input  logic [MIN_W-1:0]         minute,
	input  logic [SEC_W-1:0]         second,
	input  logic signed [OFFS_W-1:0] offset_minutes,
	input  logic [TZ_W-1:0]          tz_limit,
	output cal_t                     cal_s3
);

	// stage 1
	logic [16:0] ym1_w, x400_w, x25_w;
	logic [22:0] p400_w;
	logic [28:0] p25_w;
	logic signed [12:0] offs_x_w, lim_x_w;
	logic tz_ok_w, pre_ok_w;

	logic [15:0]              x400_s1, x25_s1;
	logic [6:0]               q400_s1;
	logic [10:0]              q25_s1;
	logic [3:0]               ylo_s1;
	logic [MONTH_W-1:0]       month_s1;
	logic [DAY_W-1:0]         day_s1;
	logic [HOUR_W-1:0]        hour_s1;
	logic [MIN_W-1:0]         minute_s1;
	logic [SEC_W-1:0]         second_s1;
	logic signed [OFFS_W-1:0] offs_s1;
	logic                     ok_s1;

	assign ym1_w  = {{2{year[YEAR_W-1]}}, year} - 17'(month <= 4'd2);
	assign x400_w = ym1_w + ERA_YEAR_BIAS;
	assign x25_w  = {{2{year[YEAR_W-1]}}, year} + Y25_BIAS;
	// exact floor division by 400 and by 25 via reciprocals over the biased range
	assign p400_w = 23'(x400_w[15:4]) * RECIP_25_A;
	assign p25_w  = 29'(x25_w[15:0]) * RECIP_25_B;

	assign offs_x_w = 13'(offset_minutes);
	assign lim_x_w  = $signed({2'b00, tz_limit});
	assign tz_ok_w  = (offs_x_w <= lim_x_w) && (offs_x_w >= -lim_x_w);
	assign pre_ok_w = (month >= 4'd1) && (month <= 4'd12) && (hour <= 5'd23)
		&& (minute <= 6'd59) && (second <= 6'd59) && tz_ok_w;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x400_s1   <= x400_w[15:0];
			x25_s1    <= x25_w[15:0];
			q400_s1   <= p400_w[21:15];
			q25_s1    <= p25_w[27:17];
			ylo_s1    <= year[3:0];
			month_s1  <= month;
			day_s1    <= day;
			hour_s1   <= hour;
			minute_s1 <= minute;
			second_s1 <= second;
			offs_s1   <= offset_minutes;
			ok_s1     <= pre_ok_w;
		end
	end

	// stage 2
	logic [15:0] r400_w;
	logic        z25_w, leap_w, day_ok_w;
	logic [DAY_W-1:0] mlen_w;

	logic signed [7:0]  era_s2;
	logic [8:0]         yoe_s2, doy_s2;
	logic [16:0]        tod_s2;
	logic signed [17:0] o60_s2;
	logic               ok_s2;

	assign r400_w   = x400_s1 - 16'(q400_s1) * YEARS_ERA;
	assign z25_w    = (x25_s1 == 16'(q25_s1) * 16'd25);
	assign leap_w   = ((ylo_s1[1:0] == 2'd0) && !z25_w) || ((ylo_s1 == 4'd0) && z25_w);
	assign mlen_w   = month_len(month_s1, leap_w);
	assign day_ok_w = (day_s1 != 5'd0) && (day_s1 <= mlen_w);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			era_s2 <= $signed(8'(q400_s1) - ERA_BIAS);
			yoe_s2 <= r400_w[8:0];
			doy_s2 <= doy_base(month_s1) + 9'(day_s1) - 9'd1;
			tod_s2 <= 17'(hour_s1) * 17'd3600 + 17'(minute_s1) * 17'd60 + 17'(second_s1);
			o60_s2 <= 18'(offs_s1) * 18'sd60;
			ok_s2  <= ok_s1 && day_ok_w;
		end
	end

	// stage 3
	logic [1:0] c100_w;

	always_comb begin
		if (yoe_s2 >= 9'd300)
			c100_w = 2'd3;
		else if (yoe_s2 >= 9'd200)
			c100_w = 2'd2;
		else if (yoe_s2 >= 9'd100)
			c100_w = 2'd1;
		else
			c100_w = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cal_s3.ok   <= ok_s2;
			cal_s3.era  <= era_s2;
			cal_s3.doe  <= 18'(yoe_s2) * 18'd365 + 18'(yoe_s2[8:2]) - 18'(c100_w)
				+ 18'(doy_s2);
			cal_s3.tsec <= $signed({2'b00, tod_s2}) - 19'(o60_s2);
		end
	end

endmodule

// File: rtl/dte_scale.sv
// Back stages: day count, scaling to seconds, offset add and saturation.
module dte_scale import dte_pkg::*; (
	input  logic               clk,
	input  logic [2:0]         en,
	input  cal_t               cal_s3,
	output logic               ok_s6,
	output logic [EPOCH_W-1:0] epoch_s6
);

	logic signed [23:0] days_s4;
	logic signed [18:0] tsec_s4, tsec_s5;
	logic               ok_s4, ok_s5;
	logic signed [41:0] prod_s5;
	logic signed [41:0] sum_w;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			days_s4 <= 24'($signed(cal_s3.era)) * DAYS_ERA + $signed(24'(cal_s3.doe))
				- EPOCH_SHIFT;
			tsec_s4 <= cal_s3.tsec;
			ok_s4   <= cal_s3.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s5 <= 42'(days_s4) * SECS_DAY;
			tsec_s5 <= tsec_s4;
			ok_s5   <= ok_s4;
		end
	end

	assign sum_w = prod_s5 + 42'(tsec_s5);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ok_s6 <= ok_s5;
			if (!ok_s5)
				epoch_s6 <= '0;
			else if (sum_w > EPOCH_MAX)
				epoch_s6 <= EPOCH_MAX[EPOCH_W-1:0];
			else if (sum_w < EPOCH_MIN)
				epoch_s6 <= EPOCH_MIN[EPOCH_W-1:0];
			else
				epoch_s6 <= sum_w[EPOCH_W-1:0];
		end
	end

endmodule

// File: rtl/datetime_to_epoch_seconds_core.sv
// Top level: stream ports, timezone limit register and pipeline control.
//
// Converts a calendar date and time with a timezone offset into signed Unix
// epoch seconds and flags items whose fields are out of range (result zero).
// One item per clock enters unless back-pressure stalls it, and passes the
// six register stages: field checks and reciprocal divides, era split and
// leap test, day-of-era sum, day count multiply, scaling to seconds, then
// offset add with saturation into the output register. Every stage holds
// its own valid bit, so bubbles close up under back-pressure and a new item
// is taken while a finished result waits at the output if a stage is empty.
module datetime_to_epoch_seconds_core import dte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// year[14:0], month[18:15], day[23:19], hour[28:24], minute[34:29],
	// second[40:35], offset_minutes[52:41], zero pad[55:53]
	input  logic [IN_DATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// epoch_seconds[39:0]
	output logic [EPOCH_W-1:0]   m_tdata,
	// valid_res[0]
	output logic                 m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TZ_W-1:0]      cfg_data
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;
	logic [TZ_W-1:0] tz_limit_q;
	cal_t            cal_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tz_limit_q <= TZ_LIMIT_RESET;
		else if (cfg_valid)
			tz_limit_q <= cfg_data;
	end

	// a stage may load when it is empty or the stage after it loads
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= s_tvalid;
			for (int i = 1; i < NSTG; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NSTG-1];

	dte_calendar u_cal (
		.clk            (clk),
		.en             (en[2:0]),
		.year           (s_tdata[14:0]),
		.month          (s_tdata[18:15]),
		.day            (s_tdata[23:19]),
		.hour           (s_tdata[28:24]),
		.minute         (s_tdata[34:29]),
		.second         (s_tdata[40:35]),
		.offset_minutes ($signed(s_tdata[52:41])),
		.tz_limit       (tz_limit_q),
		.cal_s3         (cal_s3)
	);

	dte_scale u_scale (
		.clk      (clk),
		.en       (en[5:3]),
		.cal_s3   (cal_s3),
		.ok_s6    (m_tuser),
		.epoch_s6 (m_tdata)
	);

endmodule

// File: rtl/dte_checker.sv
// Port-level checker for the datetime to epoch seconds core, with its bind.
`include "assert_macros.svh"

module dte_checker import dte_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [IN_DATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [EPOCH_W-1:0]   m_tdata,
	input logic                 m_tuser
);

	logic in_stall, out_stall;

	assign in_stall  = s_tvalid && !s_tready;
	assign out_stall = m_tvalid && !m_tready;

	`ASSERT_IMPLY(a_inv_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "invalid nonzero")
	`ASSERT_IMPLY(a_ready_empty, clk, arst_n, !m_tvalid, s_tready, "stall while empty")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "lost result")
	`ASSERT_NEXT(a_flag_hold, clk, arst_n, out_stall, $stable(m_tuser), "flag changed")
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall, s_tvalid && $stable(s_tdata), "input dropped")

endmodule

bind datetime_to_epoch_seconds_core dte_checker u_dte_checker (.*);

// File: tb/sv/dte_epoch_checker.sv
`timescale 1ns / 1ps
// Checker for the datetime to epoch seconds core: predicts each result and compares it.
module dte_epoch_checker import dte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [EPOCH_W-1:0]   m_tdata,
	input  logic                 m_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [TZ_W-1:0]      cfg_data,
	output int                   fails,
	output int                   pending
);

	typedef struct packed {
		logic [2:0]         pad;
		logic signed [11:0] offs;
		logic [5:0]         sec;
		logic [5:0]         mins;
		logic [4:0]         hr;
		logic [4:0]         dy;
		logic [3:0]         mo;
		logic signed [14:0] yr;
	} stamp_in_t;

	typedef struct packed {
		logic               ok;
		logic [EPOCH_W-1:0] secs;
	} stamp_t;

	localparam longint EPOCH_TOP = (longint'(1) <<< (EPOCH_W - 1)) - 1;
	localparam longint EPOCH_BOT = -EPOCH_TOP - 1;

	stamp_t          stamps_due[$];
	stamp_t          want;
	logic [TZ_W-1:0] tz_limit;

	initial fails = 0;
	initial pending = 0;

	function automatic stamp_t to_epoch(input stamp_in_t it, input logic [TZ_W-1:0] lim);
		longint y, m, d, off, bound, era, yoe, doy, doe, secs;
		logic   leap, ok;
		int     mlen;
		stamp_t r;
		y = longint'(it.yr);
		m = longint'(it.mo);
		d = longint'(it.dy);
		off = longint'(it.offs);
		bound = longint'(lim);
		leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		case (it.mo)
			4'd2:                    mlen = leap ? 29 : 28;
			4'd4, 4'd6, 4'd9, 4'd11: mlen = 30;
			default:                 mlen = 31;
		endcase
		ok = m >= 1 && m <= 12 && d >= 1 && d <= mlen && it.hr <= 23 && it.mins <= 59
			&& it.sec <= 59 && off >= -bound && off <= bound;
		r = '0;
		if (ok) begin
			// March-based year, 400-year eras, day 0 at 1970-01-01
			if (m <= 2)
				y = y - 1;
			era = (y >= 0 ? y : y - 399) / 400;
			yoe = y - era * 400;
			doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			secs = (era * 146097 + doe - 719468) * 86400 + longint'(it.hr) * 3600
				+ longint'(it.mins) * 60 + longint'(it.sec) - off * 60;
			if (secs > EPOCH_TOP)
				secs = EPOCH_TOP;
			if (secs < EPOCH_BOT)
				secs = EPOCH_BOT;
			r.ok = 1'b1;
			r.secs = secs[EPOCH_W-1:0];
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_limit = TZ_LIMIT_RESET;
			stamps_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (stamps_due.size() == 0) begin
					flag_mismatch("unexpected item, epoch", $signed(m_tdata), 0);
				end else begin
					want = stamps_due.pop_front();
					if (m_tuser !== want.ok)
						flag_mismatch("valid_res", m_tuser, want.ok);
					if (m_tdata !== want.secs)
						flag_mismatch("epoch_seconds", $signed(m_tdata), $signed(want.secs));
				end
			end
			if (s_tvalid && s_tready)
				stamps_due.push_back(to_epoch(stamp_in_t'(s_tdata), tz_limit));
			if (cfg_valid && cfg_ready)
				tz_limit = cfg_data;
		end
		pending <= stamps_due.size();
	end

endmodule

// File: tb/sv/tb_datetime_to_epoch_seconds_core.sv
`timescale 1ns / 1ps
// Testbench top for the datetime to epoch seconds core: stimulus, idling and verdict.
module tb_datetime_to_epoch_seconds_core;
	import dte_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 142;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [EPOCH_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TZ_W-1:0]      cfg_data = TZ_LIMIT_RESET;

	idle_mode_t      idle_mode = IDLE_NONE;
	logic [TZ_W-1:0] tz_limit = TZ_LIMIT_RESET;
	int              fails;
	int              pending;
	int              quiet_cycles = 0;

	always #1 clk = ~clk;

	datetime_to_epoch_seconds_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	dte_epoch_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: m_tready <= $urandom_range(0, 99) >= 60;
			IDLE_BOTH: m_tready <= $urandom_range(0, 99) >= 21;
			default:   m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input int yr, input int mo, input int dy, input int hr,
			input int mi, input int se, input int off);
		int gap_pct;
		gap_pct = idle_mode == IDLE_SEND ? 60 : idle_mode == IDLE_BOTH ? 21 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, off[11:0], se[5:0], mi[5:0], hr[4:0], dy[4:0], mo[3:0], yr[14:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_limit(input logic [TZ_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tz_limit = v;
	endtask

	// mostly well-formed stamps, some with one field broken, some pure noise
	task automatic random_item();
		int yr, mo, dy, hr, mi, se, off, pick, lim;
		lim = int'(tz_limit);
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			yr = int'($urandom_range(0, 32767)) - 16384;
		else
			yr = int'($urandom_range(0, 19998)) - 9999;
		mo = $urandom_range(1, 12);
		dy = ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
		hr = $urandom_range(0, 23);
		mi = $urandom_range(0, 59);
		se = $urandom_range(0, 59);
		case ($urandom_range(0, 9))
			0:       off = lim;
			1:       off = -lim;
			default: off = int'($urandom_range(0, 2 * lim)) - lim;
		endcase
		if (pick >= 90) begin
			yr = $urandom;
			mo = $urandom;
			dy = $urandom;
			hr = $urandom;
			mi = $urandom;
			se = $urandom;
			off = $urandom;
		end else if (pick >= 70) begin
			case ($urandom_range(0, 5))
				0: mo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
				1: begin
					mo = ($urandom_range(0, 1) == 0) ? 2 : 4;
					dy = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(29, 31);
				end
				2: hr = $urandom_range(24, 31);
				3: mi = $urandom_range(60, 63);
				4: se = $urandom_range(60, 63);
				default: begin
					if (lim == 2047)
						off = -2048;
					else if ($urandom_range(0, 1) == 0)
						off = $urandom_range(lim + 1, 2047);
					else
						off = -int'($urandom_range(lim + 1, 2048));
				end
			endcase
		end
		send_item(yr, mo, dy, hr, mi, se, off);
	endtask

	initial begin
		logic [TZ_W-1:0] phase_limit;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items, limit still at its reset value
		send_item(1970, 1, 1, 0, 0, 0, 0);
		send_item(1969, 12, 31, 23, 59, 59, 0);
		send_item(2000, 2, 29, 12, 34, 56, 60);
		send_item(1900, 2, 29, 0, 0, 0, 0);
		send_item(2024, 2, 29, 6, 0, 0, -300);
		send_item(2023, 2, 29, 6, 0, 0, 0);
		send_item(0, 2, 29, 0, 0, 0, 0);
		send_item(-100, 2, 29, 0, 0, 0, 0);
		send_item(-400, 2, 29, 0, 0, 0, 0);
		send_item(-16384, 1, 1, 0, 0, 0, 0);
		send_item(16383, 12, 31, 23, 59, 59, 0);
		send_item(-9999, 3, 1, 0, 0, 0, 840);
		send_item(9999, 12, 31, 23, 59, 59, -840);
		send_item(2020, 0, 10, 0, 0, 0, 0);
		send_item(2020, 13, 10, 0, 0, 0, 0);
		send_item(2020, 15, 31, 31, 63, 63, 0);
		send_item(2020, 4, 31, 0, 0, 0, 0);
		send_item(2020, 1, 0, 0, 0, 0, 0);
		send_item(2020, 1, 31, 24, 0, 0, 0);
		send_item(2020, 1, 31, 23, 60, 0, 0);
		send_item(2020, 1, 31, 23, 59, 60, 0);
		send_item(2020, 6, 15, 12, 0, 0, 841);
		send_item(2020, 6, 15, 12, 0, 0, -841);
		send_item(2020, 6, 15, 12, 0, 0, 2047);
		send_item(2020, 6, 15, 12, 0, 0, -2048);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0:       phase_limit = '0;
				1:       phase_limit = '1;
				2:       phase_limit = TZ_LIMIT_RESET;
				4:       phase_limit = TZ_W'(1);
				default: phase_limit = TZ_W'($urandom_range(1, 2046));
			endcase
			idle_mode <= idle_mode_t'(p % 4);
			write_limit(phase_limit);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
